// ===== rtl/wcp_pkg.sv =====
// Shared types and codes for the WAV chunk header parser.
`default_nettype none

package wcp_pkg;

   // Result kinds as seen on the response channel.
   localparam logic [1:0] KIND_FORMAT  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Chunk ids as they arrive, first byte in the low bits.
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_LIST = 32'h5453_494C;
   localparam logic [31:0] TAG_FACT = 32'h7463_6166;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // One command handed from the parser front end to the output back end.
   // Fields that do not belong to the kind are zero.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] format_tag;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [7:0]  payload_byte;
      logic        payload_last;
   } wcp_cmd_type;

   // A finished result word: the command plus the computed sample count.
   typedef struct packed {
      wcp_cmd_type cmd;
      logic [31:0] sample_count;
   } wcp_rsp_type;

   // Status of the command queue as seen by the back end.
   typedef struct packed {
      logic head_valid;
      logic full;
   } wcp_qstat_type;

   // True for every chunk id the parser knows how to handle.
   function automatic logic known_tag(input logic [31:0] tag);
      return (tag == TAG_RIFF) || (tag == TAG_LIST) || (tag == TAG_FACT) ||
             (tag == TAG_FMT) || (tag == TAG_DATA);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wcp_front.sv =====
// Parser front end: walks the chunk headers and issues one command per result.
`default_nettype none

module wcp_front
   import wcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  file_byte,
   input  wire logic        first,
   output wcp_cmd_type      push_cmd,
   output logic             push
);

   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_SKIP = 3'd1;
   localparam logic [2:0] PH_FMT  = 3'd2;
   localparam logic [2:0] PH_PAY  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;
   localparam logic [2:0] PH_HALT = 3'd5;

   localparam logic [31:0] RIFF_EXTRA = 32'd4;

   logic [2:0]   phase_ff, phase_in, phase_c;
   logic [3:0]   idx_ff, idx_in, idx_c, idx_n;
   logic [31:0]  tag_ff, tag_in, tag_c, tag_w;
   logic [31:0]  len_ff, len_in, len_c, len_w;
   logic [31:0]  left_ff, left_in, left_c, left_n;
   logic [127:0] fmt_ff, fmt_in, fmt_c;
   logic [31:0]  fmt_off;
   logic         known;

   // A word with first set is handled against freshly cleared state.
   always_comb begin
      phase_c = first ? PH_HDR : phase_ff;
      idx_c   = first ? 4'd0   : idx_ff;
      tag_c   = first ? '0     : tag_ff;
      len_c   = first ? '0     : len_ff;
      left_c  = first ? '0     : left_ff;
      fmt_c   = first ? '0     : fmt_ff;
   end

   always_comb begin
      tag_w = (idx_c == 4'd0) ? '0 : tag_c;
      len_w = (idx_c == 4'd0) ? '0 : len_c;
      if (!idx_c[2]) begin
         tag_w[{idx_c[1:0], 3'b000} +: 8] = file_byte;
      end else begin
         len_w[{idx_c[1:0], 3'b000} +: 8] = file_byte;
      end
   end

   assign idx_n   = idx_c + 4'd1;
   assign left_n  = left_c - 32'd1;
   assign fmt_off = len_c - left_c;
   assign known   = known_tag(tag_w);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      left_in  = left_ff;
      fmt_in   = fmt_ff;
      push     = 1'b0;
      push_cmd = '0;
      if (accept) begin
         phase_in = phase_c;
         idx_in   = idx_c;
         tag_in   = tag_c;
         len_in   = len_c;
         left_in  = left_c;
         fmt_in   = fmt_c;
         case (phase_c)
            PH_HDR: begin
               tag_in = tag_w;
               len_in = len_w;
               idx_in = idx_n;
               if (idx_n == 4'd4 && !known) begin
                  idx_in        = 4'd0;
                  phase_in      = PH_HALT;
                  push          = 1'b1;
                  push_cmd.kind = KIND_ERROR;
               end else if (idx_n[3]) begin
                  idx_in = 4'd0;
                  if (tag_w == TAG_RIFF) begin
                     left_in  = RIFF_EXTRA;
                     phase_in = PH_SKIP;
                  end else if (tag_w == TAG_FMT) begin
                     fmt_in   = '0;
                     left_in  = len_w;
                     phase_in = (len_w != '0) ? PH_FMT : PH_HDR;
                  end else if (tag_w == TAG_DATA) begin
                     push                     = 1'b1;
                     push_cmd.kind            = KIND_FORMAT;
                     push_cmd.format_tag      = fmt_c[15:0];
                     push_cmd.channel_count   = fmt_c[31:16];
                     push_cmd.sample_rate     = fmt_c[63:32];
                     push_cmd.byte_rate       = fmt_c[95:64];
                     push_cmd.block_align     = fmt_c[111:96];
                     push_cmd.bits_per_sample = fmt_c[127:112];
                     push_cmd.data_size       = len_w;
                     left_in  = len_w;
                     phase_in = (len_w != '0) ? PH_PAY : PH_DONE;
                  end else begin
                     left_in  = len_w;
                     phase_in = (len_w != '0) ? PH_SKIP : PH_HDR;
                  end
               end
            end
            PH_SKIP: begin
               left_in = left_n;
               if (left_n == '0) begin
                  phase_in = PH_HDR;
               end
            end
            PH_FMT: begin
               // fmt bytes 0..15 lie back to back in the same order as the fields.
               if (fmt_off[31:4] == '0) begin
                  fmt_in[{fmt_off[3:0], 3'b000} +: 8] = file_byte;
               end
               left_in = left_n;
               if (left_n == '0) begin
                  phase_in = PH_HDR;
               end
            end
            PH_PAY: begin
               push                  = 1'b1;
               push_cmd.kind         = KIND_PAYLOAD;
               push_cmd.payload_byte = file_byte;
               push_cmd.payload_last = (left_c == 32'd1);
               left_in = left_n;
               if (left_n == '0) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         idx_ff   <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
         fmt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         fmt_ff   <= fmt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wcp_queue.sv =====
// Small command queue between the parser front end and the output back end.
`default_nettype none

module wcp_queue
   import wcp_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wcp_cmd_type      push_cmd,
   input  wire logic        pop,
   output wcp_cmd_type      head_cmd,
   output wcp_qstat_type    status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   wcp_cmd_type   entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign status.head_valid = (cnt_ff != '0);
   assign status.full       = (cnt_ff == FULL_CNT);
   assign head_cmd          = entry_ff[rd_ff];
   assign do_push           = push && !status.full;
   assign do_pop            = pop && status.head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wcp_back.sv =====
// Output back end: computes the sample count bit by bit and holds the result word.
`default_nettype none

module wcp_back
   import wcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wcp_cmd_type      head_cmd,
   input  wcp_qstat_type    qstat,
   output logic             pop,
   input  wire logic        out_stall,
   output logic             out_valid,
   output wcp_rsp_type      out_word
);

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_DIV  = 2'd1;
   localparam logic [1:0] BK_WAIT = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, div_ff, div_in;
   logic [32:0] trial, diff;
   logic [28:0] prod;
   logic        ge, out_free;
   wcp_cmd_type hold_ff, hold_in;
   wcp_rsp_type word_ff, word_in;
   logic        valid_ff, valid_in;

   assign out_free = !valid_ff || !out_stall;
   assign prod     = head_cmd.channel_count * head_cmd.bits_per_sample[15:3];
   assign trial    = {rem_ff, quo_ff[31]};
   assign diff     = trial - {1'b0, div_ff};
   assign ge       = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      hold_in  = hold_ff;
      word_in  = word_ff;
      valid_in = valid_ff && out_stall;
      pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (qstat.head_valid) begin
               if (head_cmd.kind == KIND_FORMAT) begin
                  pop      = 1'b1;
                  hold_in  = head_cmd;
                  div_in   = {3'b000, prod};
                  rem_in   = '0;
                  quo_in   = head_cmd.data_size;
                  cnt_in   = '0;
                  state_in = BK_DIV;
               end else if (out_free) begin
                  pop                  = 1'b1;
                  word_in.cmd          = head_cmd;
                  word_in.sample_count = '0;
                  valid_in             = 1'b1;
               end
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[31:0] : trial[31:0];
            quo_in = {quo_ff[30:0], ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = BK_WAIT;
            end
         end
         BK_WAIT: begin
            if (out_free) begin
               word_in.cmd          = hold_ff;
               word_in.sample_count = (div_ff == '0) ? '0 : quo_ff;
               valid_in             = 1'b1;
               state_in             = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      hold_ff <= hold_in;
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wav_chunk_header_parser_top.sv =====
// Top level of the WAV chunk header parser: front end, command queue and back end.
// Throughput: one file byte per cycle while the queue is not full; a format result holds its back end
// while the divider forms the sample count. Path: a payload or error word passes through the
// queue entry and then the output word register; a format word passes through the queue entry,
// the back end's divide and wait states, where the one-bit-per-cycle divider forms the sample count.
// Reset: synchronous, active high; clears parser state, the queue and the output valid flag.
`default_nettype none

module wav_chunk_header_parser_top
   import wcp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_file_byte,
   input  wire logic        req_first,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_format_tag,
   output logic [15:0]      rsp_channel_count,
   output logic [31:0]      rsp_sample_rate,
   output logic [31:0]      rsp_byte_rate,
   output logic [15:0]      rsp_block_align,
   output logic [15:0]      rsp_bits_per_sample,
   output logic [31:0]      rsp_data_size,
   output logic [31:0]      rsp_sample_count,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_last
);

   // The front end consumes a word in the cycle it is taken and, where that
   // word produces a result, writes one command into the queue at the same
   // edge. Input is held off only while the queue is full, which can happen
   // while the back end works out the sample count, and
   // whenever the receiver holds off long enough for the queue to fill.
   logic          accept;
   logic          push;
   logic          pop;
   wcp_cmd_type   push_cmd;
   wcp_cmd_type   head_cmd;
   wcp_qstat_type qstat;
   wcp_rsp_type   out_word;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   wcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .file_byte (req_file_byte),
      .first     (req_first),
      .push_cmd  (push_cmd),
      .push      (push)
   );

   wcp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (qstat)
   );

   // The back end owns the output register, so a waiting result word never
   // blocks the front end while queue space remains.
   wcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .qstat     (qstat),
      .pop       (pop),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_word  (out_word)
   );

   assign rsp_kind            = out_word.cmd.kind;
   assign rsp_format_tag      = out_word.cmd.format_tag;
   assign rsp_channel_count   = out_word.cmd.channel_count;
   assign rsp_sample_rate     = out_word.cmd.sample_rate;
   assign rsp_byte_rate       = out_word.cmd.byte_rate;
   assign rsp_block_align     = out_word.cmd.block_align;
   assign rsp_bits_per_sample = out_word.cmd.bits_per_sample;
   assign rsp_data_size       = out_word.cmd.data_size;
   assign rsp_sample_count    = out_word.sample_count;
   assign rsp_payload_byte    = out_word.cmd.payload_byte;
   assign rsp_payload_last    = out_word.cmd.payload_last;

   // Payload fields are only populated on payload words.
   a_payload_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_PAYLOAD |->
         rsp_payload_byte == 8'd0 && !rsp_payload_last)
      else $error("payload fields set on a non-payload word");

   // Format fields are only populated on format words.
   a_format_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FORMAT |->
         rsp_format_tag == 16'd0 && rsp_channel_count == 16'd0 &&
         rsp_sample_rate == 32'd0 && rsp_byte_rate == 32'd0 &&
         rsp_block_align == 16'd0 && rsp_bits_per_sample == 16'd0 &&
         rsp_data_size == 32'd0 && rsp_sample_count == 32'd0)
      else $error("format fields set on a non-format word");

   // A zero frame size must give a zero sample count, not the divider's all-ones.
   a_zero_divisor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FORMAT &&
         (rsp_channel_count == 16'd0 || rsp_bits_per_sample[15:3] == 13'd0) |->
         rsp_sample_count == 32'd0)
      else $error("non-zero sample count with a zero frame size");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for wav_chunk_header_parser_top: byte streams of WAV files in, words out.

// Scoreboard: a cycle-free model of the parser state and the queue of words it predicts.
class wav_scoreboard;
   localparam logic [31:0] RIFF_FORM_BYTES = 32'd4;
   localparam int unsigned PRINT_CAP = 100;

   typedef enum logic [2:0] {
      ST_HEADER, ST_SKIP, ST_FORMAT, ST_PAYLOAD, ST_DONE, ST_HALT
   } parse_state_t;

   parse_state_t state;
   logic [3:0]   hdr_count;
   logic [31:0]  chunk_id;
   logic [31:0]  chunk_size;
   logic [31:0]  remaining;
   logic [7:0]   fmt_body [16];

   wcp_pkg::wcp_rsp_type expected_words [$];
   int unsigned mismatches;

   function new();
      mismatches = 0;
      restart();
   endfunction

   function void restart();
      state      = ST_HEADER;
      hdr_count  = '0;
      chunk_id   = '0;
      chunk_size = '0;
      remaining  = '0;
      foreach (fmt_body[i]) fmt_body[i] = '0;
   endfunction

   function int unsigned pending();
      return expected_words.size();
   endfunction

   // Advance the model by one accepted file byte and queue any word it causes.
   function void note_byte(input logic [7:0] value, input logic start);
      wcp_pkg::wcp_rsp_type word;
      logic [15:0]     channels;
      logic [15:0]     bits;
      longint unsigned divisor;
      logic [31:0]     offset;
      if (start) restart();
      word = '0;
      case (state)
         ST_HEADER: begin
            if (hdr_count == 0) begin
               chunk_id   = '0;
               chunk_size = '0;
            end
            if (hdr_count < 4) chunk_id[8*hdr_count +: 8] = value;
            else chunk_size[8*(hdr_count-4) +: 8] = value;
            hdr_count++;
            if (hdr_count == 4 && !wcp_pkg::known_tag(chunk_id)) begin
               hdr_count = '0;
               state = ST_HALT;
               word.cmd.kind = wcp_pkg::KIND_ERROR;
               expected_words.push_back(word);
            end else if (hdr_count == 8) begin
               hdr_count = '0;
               remaining = chunk_size;
               case (chunk_id)
                  wcp_pkg::TAG_RIFF: begin
                     remaining = RIFF_FORM_BYTES;
                     state = ST_SKIP;
                  end
                  wcp_pkg::TAG_FMT: begin
                     foreach (fmt_body[i]) fmt_body[i] = '0;
                     state = (chunk_size != 0) ? ST_FORMAT : ST_HEADER;
                  end
                  wcp_pkg::TAG_DATA: begin
                     channels = {fmt_body[3], fmt_body[2]};
                     bits     = {fmt_body[15], fmt_body[14]};
                     divisor  = 64'(channels) * 64'(bits >> 3);
                     word.cmd.kind            = wcp_pkg::KIND_FORMAT;
                     word.cmd.format_tag      = {fmt_body[1], fmt_body[0]};
                     word.cmd.channel_count   = channels;
                     word.cmd.sample_rate     = {fmt_body[7], fmt_body[6], fmt_body[5],
                                                 fmt_body[4]};
                     word.cmd.byte_rate       = {fmt_body[11], fmt_body[10], fmt_body[9],
                                                 fmt_body[8]};
                     word.cmd.block_align     = {fmt_body[13], fmt_body[12]};
                     word.cmd.bits_per_sample = bits;
                     word.cmd.data_size       = chunk_size;
                     word.sample_count = (divisor != 0) ? 32'(64'(chunk_size) / divisor) : '0;
                     expected_words.push_back(word);
                     state = (chunk_size != 0) ? ST_PAYLOAD : ST_DONE;
                  end
                  default: state = (chunk_size != 0) ? ST_SKIP : ST_HEADER;
               endcase
            end
         end
         ST_SKIP: begin
            remaining--;
            if (remaining == 0) state = ST_HEADER;
         end
         ST_FORMAT: begin
            offset = chunk_size - remaining;
            if (offset < 16) fmt_body[offset[3:0]] = value;
            remaining--;
            if (remaining == 0) state = ST_HEADER;
         end
         ST_PAYLOAD: begin
            word.cmd.kind         = wcp_pkg::KIND_PAYLOAD;
            word.cmd.payload_byte = value;
            word.cmd.payload_last = (remaining == 1);
            expected_words.push_back(word);
            remaining--;
            if (remaining == 0) state = ST_DONE;
         end
         default: ;
      endcase
   endfunction

   task report(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task same(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   // Compare one accepted word with the oldest prediction.
   task check_word(input wcp_pkg::wcp_rsp_type got);
      wcp_pkg::wcp_rsp_type want;
      if (expected_words.size() == 0) begin
         report($sformatf("word of kind %0d arrived with none expected", got.cmd.kind));
         return;
      end
      want = expected_words.pop_front();
      same("kind",            got.cmd.kind,            want.cmd.kind);
      same("format_tag",      got.cmd.format_tag,      want.cmd.format_tag);
      same("channel_count",   got.cmd.channel_count,   want.cmd.channel_count);
      same("sample_rate",     got.cmd.sample_rate,     want.cmd.sample_rate);
      same("byte_rate",       got.cmd.byte_rate,       want.cmd.byte_rate);
      same("block_align",     got.cmd.block_align,     want.cmd.block_align);
      same("bits_per_sample", got.cmd.bits_per_sample, want.cmd.bits_per_sample);
      same("data_size",       got.cmd.data_size,       want.cmd.data_size);
      same("sample_count",    got.sample_count,        want.sample_count);
      same("payload_byte",    got.cmd.payload_byte,    want.cmd.payload_byte);
      same("payload_last",    got.cmd.payload_last,    want.cmd.payload_last);
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wcp_pkg::*;

   // The form type that follows a RIFF id in a proper file; the parser skips it.
   localparam logic [31:0] FORM_WAVE = 32'h4556_4157;
   // Longest stretch without a single handshake before the run is declared hung.
   // The slowest correct gap is the long receiver hold-off plus one divide.
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned BYTE_TARGET = 1650;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_file_byte = '0;
   logic        req_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_format_tag;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [31:0] rsp_byte_rate;
   logic [15:0] rsp_block_align;
   logic [15:0] rsp_bits_per_sample;
   logic [31:0] rsp_data_size;
   logic [31:0] rsp_sample_count;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_last;

   wav_scoreboard sb = new();

   // Idling odds in per cent, changed from phase to phase by the stimulus.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned counted_bytes = 0;

   // The file being assembled, and how many of its last bytes the parser ignores.
   logic [7:0]  wav_bytes [$];
   int unsigned tail_junk = 0;

   wcp_rsp_type seen_word;

   wav_chunk_header_parser_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_file_byte       (req_file_byte),
      .req_first           (req_first),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_format_tag      (rsp_format_tag),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_sample_count    (rsp_sample_count),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_last    (rsp_payload_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver: stalls at random, or for one long stretch when asked, so that the
   // command queue fills and the block has to hold off its byte input.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Monitor: every word taken on the response side goes to the scoreboard. The
   // same block runs the watchdog, which counts cycles with no handshake at all.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_word.cmd.kind            = rsp_kind;
            seen_word.cmd.format_tag      = rsp_format_tag;
            seen_word.cmd.channel_count   = rsp_channel_count;
            seen_word.cmd.sample_rate     = rsp_sample_rate;
            seen_word.cmd.byte_rate       = rsp_byte_rate;
            seen_word.cmd.block_align     = rsp_block_align;
            seen_word.cmd.bits_per_sample = rsp_bits_per_sample;
            seen_word.cmd.data_size       = rsp_data_size;
            seen_word.cmd.payload_byte    = rsp_payload_byte;
            seen_word.cmd.payload_last    = rsp_payload_last;
            seen_word.sample_count        = rsp_sample_count;
            sb.check_word(seen_word);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("wav_chunk_header_parser_top regression: fail");
            $finish;
         end
      end
   end

   // Offer one byte, after a random idle gap, and hold it until it is taken.
   // Valid is only lowered when a gap is actually inserted, so it never gets two
   // assignments in one time step.
   task automatic send_byte(input logic [7:0] value, input logic start);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_file_byte <= value;
      req_first     <= start;
      do @(posedge clock); while (req_stall);
      sb.note_byte(value, start);
   endtask

   // Send the assembled file; its first byte restarts the parser.
   task automatic send_file();
      foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == 0);
      counted_bytes += wav_bytes.size() - tail_junk;
      wav_bytes.delete();
      tail_junk = 0;
   endtask

   function automatic void put8(input logic [7:0] value);
      wav_bytes.push_back(value);
   endfunction

   // Chunk ids and sizes are both stored little-endian.
   function automatic void put32(input logic [31:0] value);
      for (int i = 0; i < 4; i++) put8(value[8*i +: 8]);
   endfunction

   function automatic void put_skip_chunk(input logic [31:0] id, input int unsigned size);
      put32(id);
      put32(size);
      repeat (size) put8(8'($urandom_range(255)));
   endfunction

   // A fmt chunk of the given size: the first 16 body bytes hold the fields and
   // anything beyond is filler that the parser skips.
   function automatic void put_fmt(input int unsigned size, input logic [15:0] ftag,
                                   input logic [15:0] chans, input logic [31:0] rate,
                                   input logic [31:0] brate, input logic [15:0] align,
                                   input logic [15:0] bits);
      logic [127:0] body;
      body = {bits, align, brate, rate, chans, ftag};
      put32(TAG_FMT);
      put32(size);
      for (int i = 0; i < size; i++) begin
         put8((i < 16) ? body[8*i +: 8] : 8'($urandom_range(255)));
      end
   endfunction

   // Data header plus the payload bytes actually sent, which may be fewer than
   // the declared size when the file is cut short by the next restart.
   function automatic void put_data(input logic [31:0] size, input int unsigned sent);
      put32(TAG_DATA);
      put32(size);
      repeat (sent) put8(8'($urandom_range(255)));
   endfunction

   function automatic void put_riff();
      put32(TAG_RIFF);
      put32($urandom);
      put32(($urandom_range(3) != 0) ? FORM_WAVE : $urandom);
   endfunction

   function automatic void put_random_fmt();
      int unsigned size;
      logic [15:0] ftag, chans, bits;
      size = ($urandom_range(99) < 70) ? 16 : $urandom_range(20);
      case ($urandom_range(3))
         0: ftag = 16'h0001;
         1: ftag = 16'h0003;
         2: ftag = 16'hFFFE;
         default: ftag = 16'($urandom);
      endcase
      case ($urandom_range(4))
         0: chans = 16'd0;
         1: chans = 16'd1;
         2: chans = 16'd2;
         3: chans = 16'hFFFF;
         default: chans = 16'($urandom);
      endcase
      case ($urandom_range(5))
         0: bits = 16'd8;
         1: bits = 16'd16;
         2: bits = 16'd24;
         3: bits = 16'd32;
         4: bits = 16'($urandom_range(7));
         default: bits = 16'($urandom);
      endcase
      put_fmt(size, ftag, chans, $urandom, $urandom, 16'($urandom), bits);
   endfunction

   // One random file. Most are well formed with random content; the rest are
   // noise, files with an unknown chunk id, or files cut short at a random byte.
   function automatic void build_random_file(input int unsigned pay_min);
      int unsigned pick, extras, fmt_slot, sent, keep;
      logic [31:0] size, bad_id;
      pick = $urandom_range(99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 30)) put8(8'($urandom_range(255)));
         return;
      end
      put_riff();
      if (pick < 14) begin
         // An id one bit away from a real one, or something arbitrary.
         do begin
            bad_id = ($urandom_range(1) != 0) ?
                     (TAG_FMT ^ (32'h1 << $urandom_range(31))) : $urandom;
         end while (known_tag(bad_id));
         put32(bad_id);
         tail_junk = $urandom_range(6);
         repeat (tail_junk) put8(8'($urandom_range(255)));
         return;
      end
      extras = $urandom_range(2);
      fmt_slot = $urandom_range(extras);
      for (int i = 0; i <= extras; i++) begin
         if (i == fmt_slot && $urandom_range(9) != 0) put_random_fmt();
         if (i < extras) begin
            put_skip_chunk(($urandom_range(1) != 0) ? TAG_LIST : TAG_FACT,
                           $urandom_range(6));
         end
      end
      if ($urandom_range(99) < 8) begin
         // A huge declared payload, abandoned after a few bytes.
         size = $urandom | 32'h0001_0000;
         sent = $urandom_range(pay_min + 1, pay_min + 12);
      end else begin
         size = (pay_min == 0 && $urandom_range(9) == 0) ? 0 :
                $urandom_range(pay_min, pay_min + 24);
         sent = size;
      end
      put_data(size, sent);
      if (sent == size) begin
         tail_junk = $urandom_range(3);
         repeat (tail_junk) put8(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 5) begin
         keep = $urandom_range(1, wav_bytes.size());
         while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
         tail_junk = 0;
      end
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed files. First the extremes: every fmt field all ones, a RIFF
      // size of all ones, a LIST body of 00 and FF, an empty fact chunk, and a
      // two-byte payload of 00 then FF followed by a byte the parser ignores.
      put32(TAG_RIFF);
      put32(32'hFFFF_FFFF);
      put32(FORM_WAVE);
      put32(TAG_LIST);
      put32(32'd2);
      put8(8'h00);
      put8(8'hFF);
      put_skip_chunk(TAG_FACT, 0);
      put_fmt(16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      put32(TAG_DATA);
      put32(32'd2);
      put8(8'h00);
      put8(8'hFF);
      put8(8'h5A);
      tail_junk = 1;
      send_file();

      // A fmt body longer than 16 bytes, then an empty data chunk.
      put_riff();
      put_fmt(18, 16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
      put_data(0, 0);
      send_file();

      // An empty fmt chunk leaves every field zero, so the divisor is zero too.
      put_riff();
      put_fmt(0, 16'd1, 16'd2, 32'd8000, 32'd16000, 16'd2, 16'd8);
      put_data(5, 5);
      send_file();

      // A short fmt body that stops before the sample width.
      put_riff();
      put_fmt(6, 16'd1, 16'd2, 32'd22050, 32'd0, 16'd0, 16'd0);
      put_data(3, 3);
      send_file();

      // Data with no fmt chunk at all.
      put_riff();
      put_data(2, 2);
      send_file();

      // An unknown chunk id halts the parser until the next restart.
      put_riff();
      put32(32'h6B6E_756A);
      repeat (4) put8(8'($urandom_range(255)));
      tail_junk = 4;
      send_file();

      // The largest data size with one byte per frame: the sample count equals
      // the size. The file is abandoned inside the payload by the next restart.
      put_riff();
      put_fmt(16, 16'd1, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
      put_data(32'hFFFF_FFFF, 3);
      send_file();

      // A restart in the middle of a chunk header.
      put_riff();
      put32(TAG_FMT);
      put8(8'h10);
      send_file();

      // Random files in four idling phases: none, sender idle, receiver
      // stalling, then both. The first phase starts with the long hold-off,
      // during which the sender keeps pushing a long payload into the block.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if (ph == 0) begin
            hold_request = 1'b1;
            put_riff();
            put_fmt(16, 16'd1, 16'd2, 32'd48000, 32'd192000, 16'd4, 16'd16);
            put_data(32'd64, 64);
            send_file();
         end
         while (counted_bytes < BYTE_TARGET * (ph + 1) / 4) begin
            build_random_file(0);
            send_file();
         end
      end
      req_valid <= 1'b0;

      // Let every predicted word arrive, then give the block time to show any
      // word that was not predicted.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));

      if (sb.mismatches == 0) begin
         $display("wav_chunk_header_parser_top regression: pass");
      end else begin
         $display("wav_chunk_header_parser_top regression: fail");
      end
      $finish;
   end

endmodule
